// ===== src/fsla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsla_pkg: shared types and codes for the free-list slot allocator
// Payload structs, command/status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fsla_pkg;

  // Default sizing
  localparam int POOL_SLOTS_DEF = 256;
  localparam int MAX_RUN_DEF    = 16;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 8;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;
  localparam int SRC_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 9'd256;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_LEN   = 2'd3;

  // Source of the granted slot field
  localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
  localparam logic [SRC_W-1:0] SRC_HEAD = 2'd1;
  localparam logic [SRC_W-1:0] SRC_BUF  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]  run_length;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] granted_slot;
    logic              last_of_run;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  peak_allocated;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic              latch_item;
    logic              spec_read;
    logic              pop_commit;
    logic              push_commit;
    logic              run_start;
    logic              walk_read;
    logic              walk_step;
    logic              run_commit;
    logic              emit_read;
    logic              emit_next;
    logic              sweep_start;
    logic              sweep_step;
    logic              sweep_done;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic [SRC_W-1:0]  out_src;
    logic              out_last;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             head_end;
    logic             cur_end;
    logic             idx_bad;
    logic             len_bad;
    logic             short_pool;
    logic             walk_last;
    logic             emit_last;
    logic             sweep_last;
    logic             out_free;
  } ctrl_stat_t;

endpackage

// ===== src/fixed_slot_free_list_allocator_core.sv =====
// Allocate one and free: accept, then pop or push.
// Allocate run of N: the chain walk and the replay from the run buffer each
// take one link or buffer read per slot.
// Flush: accept, start, one link entry rewritten per cycle, result.
// Reset and a pool_size write start the same rebuild sweep; no input is
// accepted until it ends.
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_core: free-list slot pool allocator
// Linked free list with head register, link memory, allocated count and
// high-water mark; sequencer and datapath joined by command/status bundles.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_core #(
  parameter int POOL_SLOTS = fsla_pkg::POOL_SLOTS_DEF,
  parameter int MAX_RUN    = fsla_pkg::MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [fsla_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fsla_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fsla_pkg::out_item_t        out_data
);

  import fsla_pkg::*;

  ctrl_cmd_t  ctl;
  ctrl_stat_t sts;

  fsla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  fsla_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

  // One transaction in flight: an accepted item blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction still active");

  // A register write starts the rebuild sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input not held off after pool_size write");

  // Failed results carry no grant and end the transaction
  a_fail_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |->
      (out_data.last_of_run && (out_data.granted_slot == '0)))
    else $error("failure result with grant or without last mark");

  // Free count never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.free_count) <= POOL_SLOTS))
    else $error("free count above pool capacity");

endmodule

// ===== src/fsla_ram.sv =====
// ----------------------------------------------------------------------------
// fsla_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/fsla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsla_ctrl: allocator sequencer
// Accepts one transaction at a time and steps the datapath through pop,
// push, chain walk, run emission and link rebuild sweeps.
// ----------------------------------------------------------------------------
module fsla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fsla_pkg::ctrl_stat_t sts,
  output fsla_pkg::ctrl_cmd_t  ctl
);

  import fsla_pkg::*;

  localparam logic [2:0] S_SWEEP      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_EXEC       = 3'd2;
  localparam logic [2:0] S_WALK       = 3'd3;
  localparam logic [2:0] S_WALK_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT_RD    = 3'd5;
  localparam logic [2:0] S_EMIT_WR    = 3'd6;
  localparam logic [2:0] S_FLUSH_RESP = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       flush_r, flush_nxt;
  logic       in_fire;

  assign in_stall = (state_r != S_IDLE) || cfg_we;
  assign in_fire  = in_valid && !in_stall;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    ctl       = '0;
    if (cfg_we) begin
      state_nxt = S_SWEEP;
      flush_nxt = 1'b0;
    end else begin
      case (state_r)
        S_SWEEP: begin
          ctl.sweep_step = 1'b1;
          if (sts.sweep_last) begin
            ctl.sweep_done = 1'b1;
            state_nxt      = flush_r ? S_FLUSH_RESP : S_IDLE;
          end
        end
        S_FLUSH_RESP: begin
          if (sts.out_free) begin
            ctl.out_load   = 1'b1;
            ctl.out_status = ST_OK;
            ctl.out_src    = SRC_NONE;
            ctl.out_last   = 1'b1;
            flush_nxt      = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
        S_IDLE: begin
          // head link is fetched ahead so a pop finishes in the next cycle unless the output stalls
          ctl.spec_read = 1'b1;
          if (in_fire) begin
            ctl.latch_item = 1'b1;
            state_nxt      = S_EXEC;
          end
        end
        S_EXEC: begin
          case (sts.item_cmd)
            CMD_ALLOC: begin
              if (sts.out_free) begin
                ctl.out_load = 1'b1;
                ctl.out_last = 1'b1;
                if (sts.head_end) begin
                  ctl.out_status = ST_NO_SPACE;
                  ctl.out_src    = SRC_NONE;
                end else begin
                  ctl.pop_commit = 1'b1;
                  ctl.out_status = ST_OK;
                  ctl.out_src    = SRC_HEAD;
                end
                state_nxt = S_IDLE;
              end
            end
            CMD_FREE: begin
              if (sts.out_free) begin
                ctl.out_load = 1'b1;
                ctl.out_last = 1'b1;
                ctl.out_src  = SRC_NONE;
                if (sts.idx_bad) begin
                  ctl.out_status = ST_BAD_INDEX;
                end else begin
                  ctl.push_commit = 1'b1;
                  ctl.out_status  = ST_OK;
                end
                state_nxt = S_IDLE;
              end
            end
            CMD_RUN: begin
              if (sts.len_bad || sts.short_pool) begin
                if (sts.out_free) begin
                  ctl.out_load   = 1'b1;
                  ctl.out_last   = 1'b1;
                  ctl.out_src    = SRC_NONE;
                  ctl.out_status = sts.len_bad ? ST_BAD_LEN : ST_NO_SPACE;
                  state_nxt      = S_IDLE;
                end
              end else begin
                ctl.run_start = 1'b1;
                state_nxt     = S_WALK;
              end
            end
            CMD_FLUSH: begin
              ctl.sweep_start = 1'b1;
              flush_nxt       = 1'b1;
              state_nxt       = S_SWEEP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
        S_WALK: begin
          // chain ran out before the run was complete: fail, no change
          if (sts.cur_end) begin
            if (sts.out_free) begin
              ctl.out_load   = 1'b1;
              ctl.out_last   = 1'b1;
              ctl.out_src    = SRC_NONE;
              ctl.out_status = ST_NO_SPACE;
              state_nxt      = S_IDLE;
            end
          end else begin
            ctl.walk_read = 1'b1;
            state_nxt     = S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          ctl.walk_step = 1'b1;
          if (sts.walk_last) begin
            ctl.run_commit = 1'b1;
            state_nxt      = S_EMIT_RD;
          end else begin
            state_nxt = S_WALK;
          end
        end
        S_EMIT_RD: begin
          ctl.emit_read = 1'b1;
          state_nxt     = S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (sts.out_free) begin
            ctl.out_load   = 1'b1;
            ctl.out_status = ST_OK;
            ctl.out_src    = SRC_BUF;
            ctl.out_last   = sts.emit_last;
            if (sts.emit_last) begin
              state_nxt = S_IDLE;
            end else begin
              ctl.emit_next = 1'b1;
              state_nxt     = S_EMIT_RD;
            end
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

// ===== src/fsla_dp.sv =====
// ----------------------------------------------------------------------------
// fsla_dp: allocator datapath
// Free-list head, link memory, run buffer, allocated/peak counters,
// rebuild sweep counter and the result register.
// ----------------------------------------------------------------------------
module fsla_dp #(
  parameter int POOL_SLOTS = fsla_pkg::POOL_SLOTS_DEF,
  parameter int MAX_RUN    = fsla_pkg::MAX_RUN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fsla_pkg::CNT_W-1:0]   cfg_wdata,
  input  fsla_pkg::in_item_t           in_data,
  input  logic                         out_stall,
  output logic                         out_valid,
  output fsla_pkg::out_item_t          out_data,
  input  fsla_pkg::ctrl_cmd_t          ctl,
  output fsla_pkg::ctrl_stat_t         sts
);

  import fsla_pkg::*;

  localparam int ADDR_W = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int BUF_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SLOTS);

  logic [CNT_W-1:0]  pool_size_r;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic [ADDR_W-1:0] sw_r;
  logic [LINK_W-1:0] cur_r;
  logic [RUN_W-1:0]  n_r;
  logic [RUN_W-1:0]  e_r;
  in_item_t          item_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [CNT_W-1:0]  eff_size;
  logic [CNT_W-1:0]  free_left;
  logic [CNT_W-1:0]  free_out;
  logic [CNT_W:0]    add_sum;
  logic [CNT_W-1:0]  add_sat;
  logic [LINK_W-1:0] sw_link;
  logic [SLOT_W-1:0] slot_out;

  logic              lk_we, lk_re;
  logic [ADDR_W-1:0] lk_waddr, lk_raddr;
  logic [LINK_W-1:0] lk_wdata, lk_rdata;
  logic [SLOT_W-1:0] buf_rdata;

  // Effective pool size and free slots left
  assign eff_size  = (int'(pool_size_r) > POOL_SLOTS) ? CNT_W'(POOL_SLOTS) : pool_size_r;
  assign free_left = (eff_size > alloc_r) ? (eff_size - alloc_r) : '0;

  // Status toward the controller
  always_comb begin
    sts            = '0;
    sts.item_cmd   = item_r.cmd;
    sts.head_end   = int'(head_r) >= POOL_SLOTS;
    sts.cur_end    = int'(cur_r) >= POOL_SLOTS;
    sts.idx_bad    = {1'b0, item_r.slot_index} >= eff_size;
    sts.len_bad    = (item_r.run_length == '0) || (int'(item_r.run_length) > MAX_RUN);
    sts.short_pool = free_left < CNT_W'(item_r.run_length);
    sts.walk_last  = (int'(n_r) + 1) == int'(item_r.run_length);
    sts.emit_last  = (int'(e_r) + 1) == int'(item_r.run_length);
    sts.sweep_last = int'(sw_r) == (POOL_SLOTS - 1);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Rebuild value for the swept entry
  assign sw_link = ((int'(sw_r) + 1) < int'(eff_size)) ? LINK_W'(int'(sw_r) + 1) : END_MARK;

  // Link memory ports
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    if (ctl.sweep_step) begin
      lk_we    = 1'b1;
      lk_waddr = sw_r;
      lk_wdata = sw_link;
    end else if (ctl.push_commit) begin
      lk_we    = 1'b1;
      lk_waddr = ADDR_W'(item_r.slot_index);
      lk_wdata = head_r;
    end else if (ctl.run_commit) begin
      // terminate the chain after the last granted slot
      lk_we    = 1'b1;
      lk_waddr = cur_r[ADDR_W-1:0];
      lk_wdata = END_MARK;
    end
  end

  assign lk_re    = (ctl.spec_read && !sts.head_end) || (ctl.walk_read && !sts.cur_end);
  assign lk_raddr = ctl.walk_read ? cur_r[ADDR_W-1:0] : head_r[ADDR_W-1:0];

  fsla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // Run buffer: slots collected by the walk, replayed on emission
  fsla_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_RUN)
  ) u_run_buf (
    .clk   (clk),
    .we    (ctl.walk_read),
    .waddr (n_r[BUF_AW-1:0]),
    .wdata (SLOT_W'(cur_r)),
    .re    (ctl.emit_read),
    .raddr (e_r[BUF_AW-1:0]),
    .rdata (buf_rdata)
  );

  // Allocated and peak counters
  assign add_sum = {1'b0, alloc_r} + (ctl.run_commit ? (CNT_W + 1)'(item_r.run_length)
                                                      : (CNT_W + 1)'(1));
  assign add_sat = (add_sum > {1'b0, CNT_MAX}) ? CNT_MAX : add_sum[CNT_W-1:0];

  always_comb begin
    alloc_nxt = alloc_r;
    peak_nxt  = peak_r;
    if (cfg_we) begin
      alloc_nxt = '0;
      peak_nxt  = '0;
    end else if (ctl.pop_commit || ctl.run_commit) begin
      alloc_nxt = add_sat;
      if (add_sat > peak_r) begin
        peak_nxt = add_sat;
      end
    end else if (ctl.push_commit) begin
      alloc_nxt = (alloc_r != '0) ? (alloc_r - 1'b1) : '0;
    end else if (ctl.sweep_start) begin
      alloc_nxt = '0;
    end
  end

  // Free-list head
  always_comb begin
    head_nxt = head_r;
    if (ctl.sweep_done) begin
      head_nxt = (eff_size != '0) ? '0 : END_MARK;
    end else if (ctl.pop_commit || ctl.run_commit) begin
      head_nxt = lk_rdata;
    end else if (ctl.push_commit) begin
      head_nxt = LINK_W'(item_r.slot_index);
    end
  end

  // Result fields, counts as they stand after this step
  assign free_out = (eff_size > alloc_nxt) ? (eff_size - alloc_nxt) : '0;

  always_comb begin
    case (ctl.out_src)
      SRC_HEAD: slot_out = SLOT_W'(head_r);
      SRC_BUF:  slot_out = buf_rdata;
      default:  slot_out = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      head_r      <= '0;
      alloc_r     <= '0;
      peak_r      <= '0;
      sw_r        <= '0;
      n_r         <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
      head_r  <= head_nxt;
      alloc_r <= alloc_nxt;
      peak_r  <= peak_nxt;

      if (cfg_we || ctl.sweep_start || ctl.sweep_done) begin
        sw_r <= '0;
      end else if (ctl.sweep_step) begin
        sw_r <= sw_r + 1'b1;
      end

      if (ctl.run_start) begin
        n_r <= '0;
        e_r <= '0;
      end else begin
        if (ctl.walk_step) begin
          n_r <= n_r + 1'b1;
        end
        if (ctl.emit_next) begin
          e_r <= e_r + 1'b1;
        end
      end

      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      item_r <= in_data;
    end
    if (ctl.run_start) begin
      cur_r <= head_r;
    end else if (ctl.walk_step) begin
      cur_r <= lk_rdata;
    end
    if (ctl.out_load) begin
      out_data_r.status         <= ctl.out_status;
      out_data_r.granted_slot   <= slot_out;
      out_data_r.last_of_run    <= ctl.out_last;
      out_data_r.free_count     <= free_out;
      out_data_r.peak_allocated <= peak_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
